[rtl/ipd_pkg.sv]
// Package for the IPD frame parser: phase type, character codes, sizes
// and the result record. No dependencies; every other file depends on it.
package ipd_pkg;

    // Largest frame buffer the payload length is checked against.
    localparam int BUF_DEPTH = 64;

    // Width of the payload counter and of the decimal length accumulator.
    localparam int CNT_W = $clog2(BUF_DEPTH);
    localparam int LEN_W = 16;

    // Largest accepted payload length.
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(BUF_DEPTH - 2);

    // Widths of the result fields.
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;

    // Characters the parser reacts to.
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

    // How far the "IPD," prefix has matched.
    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_I    = 2'd1;
    localparam logic [1:0] PRE_IP   = 2'd2;
    localparam logic [1:0] PRE_IPD  = 2'd3;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_WAIT = 2'd3
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              frame_end;
        logic [IDX_W-1:0]  frame_length;
    } t_result;

endpackage

[rtl/ipd_if.sv]
// Handshake channels of the IPD frame parser: received bytes in and
// payload results out. Depends on ipd_pkg for the field widths.
interface ipd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [ipd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_result_if;
    logic                       valid;
    logic                       ready;
    logic [ipd_pkg::BYTE_W-1:0] payload_byte;
    logic [ipd_pkg::IDX_W-1:0]  payload_index;
    logic                       frame_end;
    logic [ipd_pkg::IDX_W-1:0]  frame_length;

    modport source (output valid, output payload_byte, output payload_index,
                    output frame_end, output frame_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_index,
                    input frame_end, input frame_length, output ready);
endinterface

[rtl/ipd_parse.sv]
// Parser state and its one-byte update: prefix hunt, length digits,
// payload streaming and the wait for '+'. Depends on ipd_pkg.
module ipd_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ipd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_res_valid,
    output ipd_pkg::t_result           o_res
);
    import ipd_pkg::*;

    t_phase           r_phase, n_phase;
    logic [1:0]       r_prog, n_prog;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_count, n_count;

    logic [3:0]       w_digit;
    logic [LEN_W-1:0] w_cnt_ext;
    logic [LEN_W-1:0] w_cnt_inc;
    logic             w_room;
    logic             w_last;

    // Helpers shared by the next-state and output logic.
    assign w_digit   = 4'(i_byte - CH_0);
    assign w_cnt_ext = LEN_W'(r_count);
    assign w_cnt_inc = w_cnt_ext + LEN_W'(1);
    assign w_room    = (w_cnt_ext < r_acc);
    assign w_last    = (w_cnt_inc == r_acc);

    // Next state for one byte.
    always_comb begin
        n_phase = r_phase;
        n_prog  = r_prog;
        n_acc   = r_acc;
        n_count = r_count;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == CH_I && r_prog == PRE_NONE) begin
                    n_prog = PRE_I;
                end else if (i_byte == CH_P && r_prog == PRE_I) begin
                    n_prog = PRE_IP;
                end else if (i_byte == CH_D && r_prog == PRE_IP) begin
                    n_prog = PRE_IPD;
                end else if (i_byte == CH_COMMA && r_prog == PRE_IPD) begin
                    n_prog  = PRE_NONE;
                    n_phase = PH_LEN;
                end else begin
                    n_prog = PRE_NONE;
                end
            end
            PH_LEN: begin
                if (i_byte inside {[CH_0:CH_9]}) begin
                    // acc * 10 + digit, wrapping in 16 bits.
                    n_acc = {r_acc[LEN_W-4:0], 3'b000} + {r_acc[LEN_W-2:0], 1'b0}
                          + LEN_W'(w_digit);
                end else if (i_byte == CH_COLON && r_acc != '0 && r_acc <= MAX_LEN) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_HUNT;
                    n_acc   = '0;
                    n_count = '0;
                end
            end
            PH_DATA: begin
                if (w_room) begin
                    n_count = r_count + CNT_W'(1);
                    if (w_last) begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            PH_WAIT: begin
                if (i_byte == CH_PLUS) begin
                    n_phase = PH_HUNT;
                    n_acc   = '0;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_acc   = '0;
                n_count = '0;
            end
        endcase
    end

    // Result for the byte: only payload bytes produce one.
    always_comb begin
        o_res_valid         = (r_phase == PH_DATA) && w_room;
        o_res.payload_byte  = i_byte;
        o_res.payload_index = IDX_W'(r_count);
        o_res.frame_end     = w_last;
        o_res.frame_length  = IDX_W'(r_acc);
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prog  <= PRE_NONE;
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_prog  <= n_prog;
            r_acc   <= n_acc;
            r_count <= n_count;
        end
    end

    // In the payload phase the length is legal and the count is below it.
    a_data_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_acc != '0 && r_acc <= MAX_LEN && w_cnt_ext < r_acc)
        else $error("payload phase with bad length or count");

    // The last payload byte moves the parser to the wait for '+'.
    a_end_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res_valid && o_res.frame_end |=> r_phase == PH_WAIT)
        else $error("frame end did not enter the wait phase");

    // A completed prefix starts the length phase with a clean accumulator.
    a_prefix_to_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_HUNT && r_prog == PRE_IPD && i_byte == CH_COMMA
        |=> r_phase == PH_LEN && r_acc == '0 && r_count == '0)
        else $error("length phase entered with stale state");

endmodule

[rtl/ipd_out_reg.sv]
// Result register of the IPD frame parser: holds one result item until
// the receiver takes it. Depends on ipd_pkg for the result record.
module ipd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ipd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output ipd_pkg::t_result o_res
);
    import ipd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new item when empty or being emptied.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, loaded without reset.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    // A held item stays put while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_res))
        else $error("result changed while stalled");

endmodule

[rtl/ipd_frame_parser.sv]
// IPD frame parser top level: input byte register, parser and result
// register. Depends on ipd_pkg, ipd_if, ipd_parse and ipd_out_reg.
//
// Usage: received characters enter on i_rx, one byte per item. The block
// finds frames of the form "IPD,<decimal length>:<payload>" and streams
// each payload byte out on o_res with its index, the declared length and
// a mark on the last byte. Lengths from 1 to BUF_DEPTH-2 are accepted;
// after a frame, bytes are dropped until a '+'. Bytes that are not
// payload produce no result.
// Data path: a payload byte accepted on i_rx is registered in the input
// register, runs through the parser and is shown on o_res from the result
// register. The single parser update allows one byte per cycle, reached
// while no waiting result blocks a payload byte.
// Reset: i_rst_n, synchronous, clears the input and result valid flags and
// returns the parser to the prefix hunt with a zero length.
// Stall: while a result waits on o_res, one more byte can sit in the
// input register; a byte that yields no result still moves on, and
// i_rx.ready falls only when a waiting result blocks a payload byte.
module ipd_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipd_byte_if.sink     i_rx,
    ipd_result_if.source o_res
);
    import ipd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    w_has_res;
    t_result w_res;
    logic    w_out_free;
    logic    w_step;
    logic    w_accept;
    logic    w_out_valid;
    t_result w_out_res;

    // The buffered byte is processed when its result, if any, has room.
    assign w_step     = r_in_valid && (!w_has_res || w_out_free);
    assign i_rx.ready = !r_in_valid || w_step;
    assign w_accept   = i_rx.valid && i_rx.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Parser.
    ipd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_has_res),
        .o_res       (w_res)
    );

    // Result register.
    ipd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_has_res),
        .i_res   (w_res),
        .i_ready (o_res.ready),
        .o_free  (w_out_free),
        .o_valid (w_out_valid),
        .o_res   (w_out_res)
    );

    // Output channel.
    assign o_res.valid         = w_out_valid;
    assign o_res.payload_byte  = w_out_res.payload_byte;
    assign o_res.payload_index = w_out_res.payload_index;
    assign o_res.frame_end     = w_out_res.frame_end;
    assign o_res.frame_length  = w_out_res.frame_length;

    // A byte never overwrites one still waiting to be processed.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |-> !i_rx.ready)
        else $error("input register overrun");

    // A processed payload byte always lands in the result register.
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_has_res |=> w_out_valid)
        else $error("payload result lost");

endmodule
